// ===== sv/ordered_key_list_top_assert.svh =====
// ----------------------------------------------------------------------------
// ordered_key_list_top_assert.svh
// assertion macros used by the ordered key list top module
// ----------------------------------------------------------------------------
`ifndef ORDERED_KEY_LIST_TOP_ASSERT_SVH
`define ORDERED_KEY_LIST_TOP_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define OKL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequence checked in the cycle after the trigger
`define OKL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/okl_pkg.sv =====
// ----------------------------------------------------------------------------
// okl_pkg
// types and constants of the ordered key list
// ----------------------------------------------------------------------------
package okl_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CountW = 5;

  // request kinds carried on tuser
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  // sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic            ins_en;
    logic            rem_en;
    logic [KeyW-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== sv/ordered_key_list_top.sv =====
// ----------------------------------------------------------------------------
// ordered_key_list_top
// bounded ordered list of 32-bit keys built as a row of slot cells
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream: tuser carries the kind (insert,
// remove, search, clear), tdata carries the key. Each request yields one
// result beat on the master stream with ok, position and count.
// A beat is taken in the idle state; the execute state compares the key in
// all cells at once, resolves the first match through the hit chain and
// updates the cells, writing the result register. The sequencer returns to
// idle as the result is registered, so the next request can be taken while
// the result is shown, but not before the previous one has left execute.
// A stalled receiver holds the result register; a request that finishes
// while the previous result still waits stays in its execute cycle until
// the register frees up.
// Reset empties the list (fill count zero), returns the sequencer to idle
// and clears the result valid flag; slot contents are not cleared, a slot
// at or above the fill count never matches.
// ----------------------------------------------------------------------------
module ordered_key_list_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] key
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] ok, [4:1] position, [9:5] count
);

  `include "ordered_key_list_top_assert.svh"

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  okl_pkg::state_e state_q, state_d;
  okl_pkg::req_e   req_q;
  logic [okl_pkg::KeyW-1:0] key_q;
  logic [CW-1:0]   cnt_q, cnt_d;

  logic            out_valid_q;
  logic [9:0]      out_data_q, out_data_d;

  logic            in_fire, exec_fire, out_free;
  okl_pkg::cell_ctrl_t ctrl;

  logic [CAPACITY-1:0] valid, ins_here, hit, first;
  logic [CAPACITY:0]   hit_chain;
  logic [okl_pkg::KeyW-1:0] cell_key [CAPACITY];
  logic [okl_pkg::KeyW-1:0] nbr_key  [CAPACITY];

  logic                    ok;
  logic [okl_pkg::PosW-1:0] pos;
  logic                    full;

  // handshakes
  assign s_axis_tready = (state_q == okl_pkg::S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign exec_fire     = (state_q == okl_pkg::S_EXEC) && out_free;

  // request register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= okl_pkg::req_e'(s_axis_tuser);
      key_q <= s_axis_tdata;
    end
  end

  // row of cells
  assign hit_chain[0] = 1'b0;
  assign full         = (cnt_q == CW'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid[i]    = (CW'(i) < cnt_q);
    assign ins_here[i] = (CW'(i) == cnt_q);
    if (i == CAPACITY - 1) begin : g_last
      assign nbr_key[i] = key_q;
    end else begin : g_mid
      assign nbr_key[i] = cell_key[i+1];
    end

    okl_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (valid[i]),
      .ins_here_i (ins_here[i]),
      .nbr_key_i  (nbr_key[i]),
      .hit_prev_i (hit_chain[i]),
      .hit_o      (hit[i]),
      .first_o    (first[i]),
      .key_o      (cell_key[i])
    );
    assign hit_chain[i+1] = hit[i];
  end

  // position of the first match, one-hot select
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        pos = pos | okl_pkg::PosW'(i);
      end
    end
  end

  // sequencer: next state, cell controls and result
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ok         = 1'b0;
    ctrl.key   = key_q;
    ctrl.ins_en = 1'b0;
    ctrl.rem_en = 1'b0;
    out_data_d = out_data_q;
    unique case (state_q)
      okl_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = okl_pkg::S_EXEC;
        end
      end
      okl_pkg::S_EXEC: begin
        if (exec_fire) begin
          state_d = okl_pkg::S_IDLE;
          unique case (req_q)
            okl_pkg::REQ_INSERT: begin
              ok          = !full;
              ctrl.ins_en = !full;
              if (!full) begin
                cnt_d = cnt_q + CW'(1);
              end
            end
            okl_pkg::REQ_REMOVE: begin
              ok          = hit_chain[CAPACITY];
              ctrl.rem_en = hit_chain[CAPACITY];
              if (hit_chain[CAPACITY]) begin
                cnt_d = cnt_q - CW'(1);
              end
            end
            okl_pkg::REQ_SEARCH: begin
              ok = hit_chain[CAPACITY];
            end
            okl_pkg::REQ_CLEAR: begin
              ok    = 1'b1;
              cnt_d = '0;
            end
            default: begin
              ok = 1'b0;
            end
          endcase
          out_data_d = {okl_pkg::CountW'(cnt_d),
                        (req_q == okl_pkg::REQ_SEARCH) ? pos : okl_pkg::PosW'(0),
                        ok};
        end
      end
      default: begin
        state_d = okl_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= okl_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q};

  // checks
  `OKL_ASSERT(a_cnt_bound, cnt_q <= CW'(CAPACITY), "fill count above capacity")
  `OKL_ASSERT(a_first_unique, $onehot0(first), "more than one first match")
  `OKL_ASSERT_NEXT(a_ins_count,
    exec_fire && req_q == okl_pkg::REQ_INSERT && !full,
    cnt_q == $past(cnt_q) + CW'(1), "insert did not grow the list")
  `OKL_ASSERT_NEXT(a_exec_result, exec_fire, m_axis_tvalid,
    "finished request left no result")

endmodule

// ===== sv/okl_cell.sv =====
// ----------------------------------------------------------------------------
// okl_cell
// one list slot: holds a key, compares it and shifts toward the head
// ----------------------------------------------------------------------------
module okl_cell (
  input  logic                         clk_i,
  input  okl_pkg::cell_ctrl_t          ctrl_i,
  input  logic                         valid_i,     // slot below the fill count
  input  logic                         ins_here_i,  // slot equal to the fill count
  input  logic [okl_pkg::KeyW-1:0]     nbr_key_i,   // key of the next slot
  input  logic                         hit_prev_i,  // match in an earlier slot
  output logic                         hit_o,
  output logic                         first_o,
  output logic [okl_pkg::KeyW-1:0]     key_o
);

  logic [okl_pkg::KeyW-1:0] key_q, key_d;
  logic                     match;

  // compare and pass the hit along the chain
  assign match   = valid_i && (key_q == ctrl_i.key);
  assign hit_o   = hit_prev_i | match;
  assign first_o = match & ~hit_prev_i;
  assign key_o   = key_q;

  // append at the tail, or close the gap left by a removal
  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins_en && ins_here_i) begin
      key_d = ctrl_i.key;
    end else if (ctrl_i.rem_en && hit_o) begin
      key_d = nbr_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule
